FILE: hw/rtl/phsu_pkg.sv
// shared widths, latencies, register codes and types of the phong shading unit
package phsu_pkg;

    // default width of the shininess exponent walk
    localparam int EXPONENT_BITS_DEF = 8;

    // datapath widths
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int NORM_W   = 30;
    localparam int NORM_TOP = NORM_W - 1;
    localparam int LZ_W     = 6;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = 31;
    localparam int FRAC_W   = 14;
    localparam int UNIT_W   = 16;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int NUM_W    = NORM_W + FRAC_W + 1;

    // configuration widths
    localparam int GAIN_W  = 16;
    localparam int SHINE_W = 8;
    localparam int CH_W    = 16;
    localparam int RGB_W   = 3 * CH_W;
    localparam int CFG_W   = RGB_W;
    localparam int IDX_W   = 3;

    // one in Q1.14
    localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

    // unitize latency: abs, max, shift, square, sum, root, numerator, divide, sign
    localparam int UNIT_LAT = 5 + ROOT_W + 1 + QUO_W + 1;

    typedef enum logic [IDX_W-1:0] {
        CFG_DIFFUSE  = 3'd0,
        CFG_SPECULAR = 3'd1,
        CFG_SHINE    = 3'd2,
        CFG_SURFACE  = 3'd3,
        CFG_LAMP     = 3'd4,
        CFG_MODE     = 3'd5
    } cfg_idx_t;

    typedef logic [2:0][DIFF_W-1:0] diff_vec_t;
    typedef logic [2:0][UNIT_W-1:0] unit_vec_t;

    // specular base handed to the power pipeline
    typedef struct packed {
        logic             on;
        logic [QUO_W-1:0] base;
    } spec_t;

endpackage

FILE: hw/rtl/phong_shading_unit_top.sv
// phong shading unit top level: config registers, shading pipeline, output stage
//
// Phong shading unit. One hit beat on the hit channel (hit point, unit normal,
// eye point, lamp point or direction) yields one beat on the shade channel
// with saturated red, green and blue radiance in Q8.8 and the lit flag.
// Configuration (gains, shininess, surface and lamp colors, mode) is written
// through cfg_wen/cfg_idx/cfg_data, one register per cycle; the user must
// write only while no beat is in flight, which the block does not enforce;
// unknown indexes are dropped. Throughput: one beat per cycle while the
// receiver does not stall. The pipeline depth is set by the bit-per-stage
// square root (31 stages) and divider (15 stages) of the vector normalizers
// and the two multiply stages per exponent bit of the power pipeline.
// Reset empties the pipeline and loads the register defaults: full diffuse,
// half specular, exponent 16, white surface, unit lamp, point light mode.
// When the receiver stalls a finished beat, the whole pipeline holds and
// hit_ready drops; nothing is lost or repeated.
module phong_shading_unit_top #(
    parameter int EXPONENT_BITS = phsu_pkg::EXPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [phsu_pkg::IDX_W-1:0]    cfg_idx,
    input  logic [phsu_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          hit_valid,
    output logic                          hit_ready,
    input  logic [31:0]                   hit_x,
    input  logic [31:0]                   hit_y,
    input  logic [31:0]                   hit_z,
    input  logic [15:0]                   norm_x,
    input  logic [15:0]                   norm_y,
    input  logic [15:0]                   norm_z,
    input  logic [31:0]                   eye_x,
    input  logic [31:0]                   eye_y,
    input  logic [31:0]                   eye_z,
    input  logic [31:0]                   lamp_x,
    input  logic [31:0]                   lamp_y,
    input  logic [31:0]                   lamp_z,
    output logic                          shade_valid,
    input  logic                          shade_ready,
    output logic [15:0]                   out_red,
    output logic [15:0]                   out_green,
    output logic [15:0]                   out_blue,
    output logic                          lit
);

    localparam int DW     = phsu_pkg::DIFF_W;
    localparam int UW     = phsu_pkg::UNIT_W;
    localparam int QW     = phsu_pkg::QUO_W;
    localparam int FW     = phsu_pkg::FRAC_W;
    localparam int GW     = phsu_pkg::GAIN_W;
    localparam int CW     = phsu_pkg::CH_W;
    localparam int PA_W   = 2 * UW;
    localparam int DOT_W  = PA_W + 2;
    localparam int PR_W   = 2 * UW;
    localparam int R_W    = 19;
    localparam int PB_W   = R_W + UW;
    localparam int DOT2_W = PB_W + 2;
    localparam int KA_W   = GW + QW;
    localparam int F_W    = 17;
    localparam int FC_W   = F_W + CW;
    localparam int FCL_W  = FC_W + CW;
    localparam int PW_LAT = 2 * EXPONENT_BITS;
    localparam int UL     = phsu_pkg::UNIT_LAT;
    localparam int PIPE   = 1 + UL + 6 + PW_LAT + 4;

    // configuration registers
    logic [GW-1:0]                diffuse_reg;
    logic [GW-1:0]                specular_reg;
    logic [phsu_pkg::SHINE_W-1:0] shine_reg;
    logic [phsu_pkg::RGB_W-1:0]   surface_reg;
    logic [phsu_pkg::RGB_W-1:0]   lamp_reg;
    logic                         mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diffuse_reg  <= 16'hFFFF;
            specular_reg <= 16'h8000;
            shine_reg    <= 8'd16;
            surface_reg  <= 48'hFFFF_FFFF_FFFF;
            lamp_reg     <= 48'h0100_0100_0100;
            mode_reg     <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (phsu_pkg::cfg_idx_t'(cfg_idx))
                phsu_pkg::CFG_DIFFUSE:  diffuse_reg  <= cfg_data[GW-1:0];
                phsu_pkg::CFG_SPECULAR: specular_reg <= cfg_data[GW-1:0];
                phsu_pkg::CFG_SHINE:    shine_reg    <= cfg_data[phsu_pkg::SHINE_W-1:0];
                phsu_pkg::CFG_SURFACE:  surface_reg  <= cfg_data[phsu_pkg::RGB_W-1:0];
                phsu_pkg::CFG_LAMP:     lamp_reg     <= cfg_data[phsu_pkg::RGB_W-1:0];
                phsu_pkg::CFG_MODE:     mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    logic            adv;
    logic [PIPE-1:0] vld_reg;
    logic            shade_valid_reg;

    assign adv       = !shade_valid_reg || shade_ready;
    assign hit_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            shade_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg         <= {vld_reg[PIPE-2:0], hit_valid};
            shade_valid_reg <= vld_reg[PIPE-1];
        end
    end

    // difference vectors
    logic [2:0][31:0]  hit_v, eye_v, lamp_v;
    phsu_pkg::diff_vec_t dvo_next, dvi_next, dvo_reg, dvi_reg;
    phsu_pkg::unit_vec_t nrm_reg;

    assign hit_v  = {hit_z, hit_y, hit_x};
    assign eye_v  = {eye_z, eye_y, eye_x};
    assign lamp_v = {lamp_z, lamp_y, lamp_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvo_next[i] = DW'($signed(eye_v[i])) - DW'($signed(hit_v[i]));
            dvi_next[i] = mode_reg ? DW'($signed(lamp_v[i])) :
                          DW'($signed(lamp_v[i])) - DW'($signed(hit_v[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvo_reg <= dvo_next;
            dvi_reg <= dvi_next;
            nrm_reg <= {norm_z, norm_y, norm_x};
        end
    end

    // view and light unit vectors
    phsu_pkg::unit_vec_t wo, wi;

    phsu_unitize u_view (
        .clk  (clk),
        .en   (adv),
        .vec  (dvo_reg),
        .unit (wo)
    );

    phsu_unitize u_light (
        .clk  (clk),
        .en   (adv),
        .vec  (dvi_reg),
        .unit (wi)
    );

    // normal waits for the normalizers
    phsu_pkg::unit_vec_t nrm_dl_reg [UL];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nrm_dl_reg[0] <= nrm_reg;
            for (int k = 1; k < UL; k++)
            begin
                nrm_dl_reg[k] <= nrm_dl_reg[k-1];
            end
        end
    end

    // diffuse cosine and reflection
    logic signed [PA_W-1:0]   pa1_reg [3];
    phsu_pkg::unit_vec_t      nrm1_reg, wo1_reg, wi1_reg;
    logic signed [DOT_W-1:0]  dot_next;
    logic [DOT_W-FW-1:0]      ash;
    logic [QW-1:0]            a_next, a2_reg;
    logic                     lit2_reg;
    phsu_pkg::unit_vec_t      nrm2_reg, wo2_reg, wi2_reg;
    logic signed [PR_W-1:0]   pr3_reg [3];
    phsu_pkg::unit_vec_t      wo3_reg, wi3_reg;
    logic [QW-1:0]            a3_reg;
    logic                     lit3_reg;
    logic signed [R_W-1:0]    r4_reg [3];
    phsu_pkg::unit_vec_t      wo4_reg;
    logic [QW-1:0]            a4_reg;
    logic                     lit4_reg;
    logic signed [PB_W-1:0]   pb5_reg [3];
    logic [QW-1:0]            a5_reg;
    logic                     lit5_reg;
    logic signed [DOT2_W-1:0] dot2_next;
    logic [DOT2_W-FW-1:0]     bsh;
    phsu_pkg::spec_t          spec_next, spec6_reg;
    logic [QW-1:0]            a6_reg;
    logic                     lit6_reg;

    always_comb
    begin
        dot_next = DOT_W'(pa1_reg[0]) + DOT_W'(pa1_reg[1]) + DOT_W'(pa1_reg[2]);
        ash      = dot_next[DOT_W-1:FW];
        if (dot_next <= 0)
        begin
            a_next = '0;
        end
        else if (ash > (DOT_W - FW)'(phsu_pkg::ONE_Q14))
        begin
            a_next = phsu_pkg::ONE_Q14;
        end
        else
        begin
            a_next = ash[QW-1:0];
        end

        dot2_next = DOT2_W'(pb5_reg[0]) + DOT2_W'(pb5_reg[1]) + DOT2_W'(pb5_reg[2]);
        bsh       = dot2_next[DOT2_W-1:FW];
        spec_next.on = dot2_next > 0;
        if (bsh > (DOT2_W - FW)'(phsu_pkg::ONE_Q14))
        begin
            spec_next.base = phsu_pkg::ONE_Q14;
        end
        else
        begin
            spec_next.base = bsh[QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // n . wi products
            for (int i = 0; i < 3; i++)
            begin
                pa1_reg[i] <= $signed(nrm_dl_reg[UL-1][i]) * $signed(wi[i]);
            end
            nrm1_reg <= nrm_dl_reg[UL-1];
            wo1_reg  <= wo;
            wi1_reg  <= wi;

            // clamped cosine
            a2_reg   <= a_next;
            lit2_reg <= dot_next > 0;
            nrm2_reg <= nrm1_reg;
            wo2_reg  <= wo1_reg;
            wi2_reg  <= wi1_reg;

            // a * n products
            for (int i = 0; i < 3; i++)
            begin
                pr3_reg[i] <= $signed({1'b0, a2_reg}) * $signed(nrm2_reg[i]);
            end
            wo3_reg  <= wo2_reg;
            wi3_reg  <= wi2_reg;
            a3_reg   <= a2_reg;
            lit3_reg <= lit2_reg;

            // reflected vector
            for (int i = 0; i < 3; i++)
            begin
                r4_reg[i] <= R_W'(pr3_reg[i] >>> (FW - 1)) - R_W'($signed(wi3_reg[i]));
            end
            wo4_reg  <= wo3_reg;
            a4_reg   <= a3_reg;
            lit4_reg <= lit3_reg;

            // r . wo products
            for (int i = 0; i < 3; i++)
            begin
                pb5_reg[i] <= r4_reg[i] * $signed(wo4_reg[i]);
            end
            a5_reg   <= a4_reg;
            lit5_reg <= lit4_reg;

            // specular base
            spec6_reg <= spec_next;
            a6_reg    <= a5_reg;
            lit6_reg  <= lit5_reg;
        end
    end

    // specular power
    logic [QW-1:0] pow;

    phsu_power #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_power (
        .clk   (clk),
        .en    (adv),
        .shine (shine_reg),
        .spec  (spec6_reg),
        .pow   (pow)
    );

    logic [QW-1:0]     a_dl_reg [PW_LAT];
    logic [PW_LAT-1:0] lit_dl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dl_reg[0] <= a6_reg;
            for (int k = 1; k < PW_LAT; k++)
            begin
                a_dl_reg[k] <= a_dl_reg[k-1];
            end
            lit_dl_reg <= {lit_dl_reg[PW_LAT-2:0], lit6_reg};
        end
    end

    // reflectance and color
    logic [KA_W-1:0]          kda1_reg, ksp1_reg;
    logic                     lit_f1_reg, lit_f2_reg, lit_f3_reg, lit_f4_reg;
    logic [KA_W:0]            fsum;
    logic [F_W-1:0]           f2_reg;
    logic [2:0][FC_W-1:0]     fc3_reg, fc4_reg;
    logic [2:0][FCL_W-1:0]    fcl4_reg;
    logic [2:0][CW-1:0]       ch_next, ch_reg;
    logic                     lit_reg;

    assign fsum = (KA_W + 1)'(kda1_reg) + (KA_W + 1)'(ksp1_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!lit_f4_reg)
            begin
                ch_next[i] = '0;
            end
            else if (mode_reg)
            begin
                ch_next[i] = CW'(fc4_reg[i][FC_W-1:24]);
            end
            else if (fcl4_reg[i][FCL_W-1])
            begin
                ch_next[i] = '1;
            end
            else
            begin
                ch_next[i] = fcl4_reg[i][FCL_W-2:32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // gain products
            kda1_reg   <= KA_W'(diffuse_reg) * KA_W'(a_dl_reg[PW_LAT-1]);
            ksp1_reg   <= KA_W'(specular_reg) * KA_W'(pow);
            lit_f1_reg <= lit_dl_reg[PW_LAT-1];

            // reflectance f in Q.16
            f2_reg     <= fsum[FW +: F_W];
            lit_f2_reg <= lit_f1_reg;

            // times surface color, red in the top channel
            for (int i = 0; i < 3; i++)
            begin
                fc3_reg[i] <= FC_W'(f2_reg) * FC_W'(surface_reg[(2 - i) * CW +: CW]);
            end
            lit_f3_reg <= lit_f2_reg;

            // times lamp color
            for (int i = 0; i < 3; i++)
            begin
                fcl4_reg[i] <= FCL_W'(fc3_reg[i]) * FCL_W'(lamp_reg[(2 - i) * CW +: CW]);
            end
            fc4_reg    <= fc3_reg;
            lit_f4_reg <= lit_f3_reg;

            // output register
            ch_reg  <= ch_next;
            lit_reg <= lit_f4_reg;
        end
    end

    assign shade_valid = shade_valid_reg;
    assign out_red     = ch_reg[0];
    assign out_green   = ch_reg[1];
    assign out_blue    = ch_reg[2];
    assign lit         = lit_reg;

`ifndef NO_ASSERTIONS
    // an unlit beat carries black
    a_unlit_black: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && !lit |-> out_red == '0 && out_green == '0 && out_blue == '0)
        else $error("unlit beat with nonzero color");

    // a held pipeline keeps its valid bits
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // a taken beat with nothing behind it empties the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && shade_ready && !vld_reg[PIPE-1] |=> !shade_valid)
        else $error("output beat repeated");

    // the cosine never exceeds one
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2 + UL] |-> a2_reg <= phsu_pkg::ONE_Q14)
        else $error("diffuse cosine above one");
`endif

endmodule

FILE: hw/rtl/phsu_isqrt.sv
// pipelined integer square root, one result bit per stage
module phsu_isqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [phsu_pkg::SUM_W-1:0]   radicand,
    output logic [phsu_pkg::ROOT_W-1:0]  root
);

    localparam int SW = phsu_pkg::SUM_W;
    localparam int RW = phsu_pkg::ROOT_W;
    localparam int TW = SW + 1;

    logic [SW-1:0] rem_reg  [RW-1];
    logic [RW-1:0] root_reg [RW];

    genvar s;
    generate
        for (s = 0; s < RW; s++)
        begin : g_step
            localparam int K = RW - 1 - s;
            logic [SW-1:0] rem_in;
            logic [RW-1:0] root_in;
            logic [TW-1:0] trial;
            logic          take;

            if (s == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
            end

            // (root + 2^k)^2 - root^2
            assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
            assign take  = TW'(rem_in) >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[s] <= take ? (root_in | (RW'(1) << K)) : root_in;
                end
            end

            if (s < RW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s] <= take ? SW'(TW'(rem_in) - trial) : rem_in;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

FILE: hw/rtl/phsu_divide.sv
// pipelined restoring divider, three numerators over one shared divisor
module phsu_divide (
    input  logic                                clk,
    input  logic                                en,
    input  logic [2:0][phsu_pkg::NUM_W-1:0]     num,
    input  logic [phsu_pkg::ROOT_W-1:0]         den,
    output logic [2:0][phsu_pkg::QUO_W-1:0]     quo
);

    localparam int NW = phsu_pkg::NUM_W;
    localparam int QW = phsu_pkg::QUO_W;
    localparam int RW = phsu_pkg::ROOT_W;
    localparam int DW = NW + 1;

    logic [2:0][NW-1:0] rem_reg [QW-1];
    logic [RW-1:0]      den_reg [QW-1];
    logic [2:0][QW-1:0] quo_reg [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_step
            localparam int K = QW - 1 - s;
            logic [2:0][NW-1:0] rem_in;
            logic [RW-1:0]      den_in;
            logic [2:0][QW-1:0] quo_in;
            logic [2:0][NW-1:0] rem_next;
            logic [2:0][QW-1:0] quo_next;
            logic [DW-1:0]      trial;

            if (s == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            assign trial = DW'(den_in) << K;

            // compare and subtract per lane
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (DW'(rem_in[i]) >= trial)
                    begin
                        rem_next[i] = NW'(DW'(rem_in[i]) - trial);
                        quo_next[i] = quo_in[i] | (QW'(1) << K);
                    end
                    else
                    begin
                        rem_next[i] = rem_in[i];
                        quo_next[i] = quo_in[i];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[s] <= quo_next;
                end
            end

            if (s < QW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s] <= rem_next;
                        den_reg[s] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

FILE: hw/rtl/phsu_unitize.sv
// vector normalizer: scale, square sum, root and per-lane divide
module phsu_unitize (
    input  logic                  clk,
    input  logic                  en,
    input  phsu_pkg::diff_vec_t   vec,
    output phsu_pkg::unit_vec_t   unit
);

    localparam int DW  = phsu_pkg::DIFF_W;
    localparam int NMW = phsu_pkg::NORM_W;
    localparam int LW  = phsu_pkg::LZ_W;
    localparam int QW  = phsu_pkg::QUO_W;
    localparam int RW  = phsu_pkg::ROOT_W;
    localparam int UW  = phsu_pkg::UNIT_W;

    typedef struct packed {
        logic [2:0][NMW-1:0] nm;
        logic [2:0]          neg;
        logic                zero;
    } side_t;

    // stage 0: magnitudes and signs
    logic [2:0][DW-1:0] mag0_next, mag0_reg;
    logic [2:0]         neg0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag0_next[i] = vec[i][DW-1] ? (~vec[i] + DW'(1)) : vec[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg <= mag0_next;
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= vec[i][DW-1];
            end
        end
    end

    // stage 1: largest magnitude and its leading one
    logic [DW-1:0]      mx;
    logic [LW-1:0]      pos_next, pos1_reg;
    logic [2:0][DW-1:0] mag1_reg;
    logic [2:0]         neg1_reg;
    logic               zero1_reg;

    always_comb
    begin
        mx = mag0_reg[0];
        if (mag0_reg[1] > mx)
        begin
            mx = mag0_reg[1];
        end
        if (mag0_reg[2] > mx)
        begin
            mx = mag0_reg[2];
        end
        pos_next = '0;
        for (int k = 0; k < DW; k++)
        begin
            if (mx[k])
            begin
                pos_next = LW'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag0_reg;
            neg1_reg  <= neg0_reg;
            pos1_reg  <= pos_next;
            zero1_reg <= (mx == '0);
        end
    end

    // stage 2: bring the largest magnitude into [2^29, 2^30)
    side_t         side2_next, side2_reg;
    logic [DW-1:0] shifted;

    always_comb
    begin
        side2_next.neg  = neg1_reg;
        side2_next.zero = zero1_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (pos1_reg >= LW'(phsu_pkg::NORM_TOP))
            begin
                shifted = mag1_reg[i] >> (pos1_reg - LW'(phsu_pkg::NORM_TOP));
            end
            else
            begin
                shifted = mag1_reg[i] << (LW'(phsu_pkg::NORM_TOP) - pos1_reg);
            end
            side2_next.nm[i] = shifted[NMW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side2_next;
        end
    end

    // stage 3: squares
    logic [2:0][phsu_pkg::SQ_W-1:0] sq3_reg;
    side_t                          side3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= phsu_pkg::SQ_W'(side2_reg.nm[i]) *
                              phsu_pkg::SQ_W'(side2_reg.nm[i]);
            end
            side3_reg <= side2_reg;
        end
    end

    // stage 4: sum of squares
    logic [phsu_pkg::SUM_W-1:0] sum4_reg;
    side_t                      side4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum4_reg  <= phsu_pkg::SUM_W'(sq3_reg[0]) + phsu_pkg::SUM_W'(sq3_reg[1]) +
                         phsu_pkg::SUM_W'(sq3_reg[2]);
            side4_reg <= side3_reg;
        end
    end

    // length
    logic [RW-1:0] root;

    phsu_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum4_reg),
        .root     (root)
    );

    // side data across the root pipeline
    side_t side_dl_reg [RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dl_reg[0] <= side4_reg;
            for (int k = 1; k < RW; k++)
            begin
                side_dl_reg[k] <= side_dl_reg[k-1];
            end
        end
    end

    // numerators with rounding half of the length
    logic [2:0][phsu_pkg::NUM_W-1:0] num_reg;
    logic [RW-1:0]                   den_reg;
    logic [3:0]                      flg_num_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= phsu_pkg::NUM_W'({side_dl_reg[RW-1].nm[i],
                                                phsu_pkg::FRAC_W'(0)}) +
                              phsu_pkg::NUM_W'(root >> 1);
            end
            den_reg     <= root;
            flg_num_reg <= {side_dl_reg[RW-1].zero, side_dl_reg[RW-1].neg};
        end
    end

    logic [2:0][QW-1:0] quo;

    phsu_divide u_divide (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // zero flag and signs across the divider
    logic [3:0] flg_dl_reg [QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_dl_reg[0] <= flg_num_reg;
            for (int k = 1; k < QW; k++)
            begin
                flg_dl_reg[k] <= flg_dl_reg[k-1];
            end
        end
    end

    // signed unit components
    phsu_pkg::unit_vec_t unit_next, unit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (flg_dl_reg[QW-1][3])
            begin
                unit_next[i] = '0;
            end
            else if (flg_dl_reg[QW-1][i])
            begin
                unit_next[i] = UW'(0) - UW'(quo[i]);
            end
            else
            begin
                unit_next[i] = UW'(quo[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule

FILE: hw/rtl/phsu_power.sv
// specular power by square and multiply, one multiply per stage
module phsu_power #(
    parameter int EXPONENT_BITS = phsu_pkg::EXPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [phsu_pkg::SHINE_W-1:0]  shine,
    input  phsu_pkg::spec_t               spec,
    output logic [phsu_pkg::QUO_W-1:0]    pow
);

    localparam int QW = phsu_pkg::QUO_W;
    localparam int NS = 2 * EXPONENT_BITS;

    logic [QW-1:0] p_reg [NS];
    logic [QW-1:0] b_reg [NS-1];
    logic [NS-1:0] on_reg;

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_step
            localparam int BI = EXPONENT_BITS - 1 - s / 2;
            logic [QW-1:0]   p_in;
            logic [QW-1:0]   b_in;
            logic            on_in;
            logic [QW-1:0]   opnd;
            logic            use_it;
            logic [2*QW-1:0] prod;

            if (s == 0)
            begin : g_first
                assign p_in  = phsu_pkg::ONE_Q14;
                assign b_in  = spec.base;
                assign on_in = spec.on;
            end
            else
            begin : g_rest
                assign p_in  = p_reg[s-1];
                assign b_in  = b_reg[s-1];
                assign on_in = on_reg[s-1];
            end

            // even stages square, odd stages multiply by the base on a set bit
            if (s % 2 == 0)
            begin : g_sq
                assign opnd   = p_in;
                assign use_it = 1'b1;
            end
            else if (BI < phsu_pkg::SHINE_W)
            begin : g_mul
                assign opnd   = b_in;
                assign use_it = shine[BI];
            end
            else
            begin : g_none
                assign opnd   = b_in;
                assign use_it = 1'b0;
            end

            assign prod = (2 * QW)'(p_in) * (2 * QW)'(opnd);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg[s]  <= use_it ? prod[phsu_pkg::FRAC_W +: QW] : p_in;
                    on_reg[s] <= on_in;
                end
            end

            if (s < NS - 1)
            begin : g_base
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        b_reg[s] <= b_in;
                    end
                end
            end
        end
    endgenerate

    assign pow = on_reg[NS-1] ? p_reg[NS-1] : '0;

endmodule

FILE: dv/tb_phong_shading_unit_top.sv
// testbench of the phong shading unit: directed and random hits against a built-in shading predictor
`timescale 1ns / 100ps

module tb_phong_shading_unit_top;

    localparam int EXP_BITS = phsu_pkg::EXPONENT_BITS_DEF;
    localparam int LATENCY = 64 + 2 * EXP_BITS;
    localparam logic [phsu_pkg::IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam longint Q14 = 16384;

    typedef struct packed {
        logic [31:0] hx, hy, hz;
        logic [15:0] nx, ny, nz;
        logic [31:0] ex, ey, ez;
        logic [31:0] lx, ly, lz;
    } hit_t;

    typedef struct packed {
        logic [15:0] red, green, blue;
        logic        lit;
    } shade_t;

    typedef longint trip_t [3];

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wen;
    logic [phsu_pkg::IDX_W-1:0] cfg_idx;
    logic [phsu_pkg::CFG_W-1:0] cfg_data;
    logic hit_valid, hit_ready;
    logic [31:0] hit_x, hit_y, hit_z, eye_x, eye_y, eye_z, lamp_x, lamp_y, lamp_z;
    logic [15:0] norm_x, norm_y, norm_z;
    logic shade_valid, shade_ready;
    logic [15:0] out_red, out_green, out_blue;
    logic lit;

    // shadow copy of the material and lamp registers
    logic [15:0] kd_q, ks_q;
    logic [7:0]  shine_q;
    logic [47:0] surface_q, lamp_q;
    logic        mode_q;

    shade_t expected_shades[$];
    int     errors = 0;
    bit     tx_calm = 0;
    bit     rx_calm = 0;
    int     rx_hold = 0;

    phong_shading_unit_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .hit_valid(hit_valid), .hit_ready(hit_ready),
        .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .lamp_x(lamp_x), .lamp_y(lamp_y), .lamp_z(lamp_z),
        .shade_valid(shade_valid), .shade_ready(shade_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .lit(lit)
    );

    always #5 clk = ~clk;

    // integer square root, bit by bit
    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (x >= res + bt)
            begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // scale to a unit vector in Q1.14, zero stays zero
    function automatic trip_t unit_dir(trip_t v);
        logic [63:0] m [3];
        logic [63:0] mx, len, q;
        trip_t u;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            u = '{0, 0, 0};
            return u;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * Q14 + len / 2) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return u;
    endfunction

    // phong shading of one hit under the current register values
    function automatic shade_t shade_predict(hit_t h);
        trip_t hp, nv, ep, lp, dv, wo, wi, rv;
        longint dot, a, b, p, f, col, lc, ch;
        shade_t s;
        hp = '{longint'($signed(h.hx)), longint'($signed(h.hy)), longint'($signed(h.hz))};
        nv = '{longint'($signed(h.nx)), longint'($signed(h.ny)), longint'($signed(h.nz))};
        ep = '{longint'($signed(h.ex)), longint'($signed(h.ey)), longint'($signed(h.ez))};
        lp = '{longint'($signed(h.lx)), longint'($signed(h.ly)), longint'($signed(h.lz))};
        for (int i = 0; i < 3; i++)
            dv[i] = ep[i] - hp[i];
        wo = unit_dir(dv);
        for (int i = 0; i < 3; i++)
            dv[i] = mode_q ? lp[i] : lp[i] - hp[i];
        wi = unit_dir(dv);
        s = '0;
        dot = nv[0] * wi[0] + nv[1] * wi[1] + nv[2] * wi[2];
        if (dot <= 0)
            return s;
        a = dot >>> 14;
        if (a > Q14)
            a = Q14;
        // reflect the light direction about the normal
        for (int i = 0; i < 3; i++)
            rv[i] = ((2 * a * nv[i]) >>> 14) - wi[i];
        dot = rv[0] * wo[0] + rv[1] * wo[1] + rv[2] * wo[2];
        p = 0;
        if (dot > 0)
        begin
            b = dot >>> 14;
            if (b > Q14)
                b = Q14;
            p = Q14;
            for (int i = EXP_BITS - 1; i >= 0; i--)
            begin
                p = (p * p) >>> 14;
                if (i < 8 && shine_q[i])
                    p = (p * b) >>> 14;
            end
        end
        f = (longint'(kd_q) * a + longint'(ks_q) * p) >>> 14;
        for (int i = 0; i < 3; i++)
        begin
            col = longint'(surface_q[32 - 16 * i +: 16]);
            lc = longint'(lamp_q[32 - 16 * i +: 16]);
            ch = mode_q ? (f * col) >>> 24 : (f * col * lc) >>> 32;
            if (ch > 65535)
                ch = 65535;
            if (i == 0)
                s.red = ch[15:0];
            else if (i == 1)
                s.green = ch[15:0];
            else
                s.blue = ch[15:0];
        end
        s.lit = 1'b1;
        return s;
    endfunction

    // register write with the shadow kept in step
    task automatic cfg_write(logic [phsu_pkg::IDX_W-1:0] idx, logic [phsu_pkg::CFG_W-1:0] d);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            phsu_pkg::CFG_DIFFUSE:  kd_q = d[15:0];
            phsu_pkg::CFG_SPECULAR: ks_q = d[15:0];
            phsu_pkg::CFG_SHINE:    shine_q = d[7:0];
            phsu_pkg::CFG_SURFACE:  surface_q = d[47:0];
            phsu_pkg::CFG_LAMP:     lamp_q = d[47:0];
            phsu_pkg::CFG_MODE:     mode_q = d[0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [15:0] kd, logic [15:0] ks, logic [7:0] sh,
                           logic [47:0] srf, logic [47:0] lmp, logic md);
        cfg_write(phsu_pkg::CFG_DIFFUSE, phsu_pkg::CFG_W'(kd));
        cfg_write(phsu_pkg::CFG_SPECULAR, phsu_pkg::CFG_W'(ks));
        cfg_write(phsu_pkg::CFG_SHINE, phsu_pkg::CFG_W'(sh));
        cfg_write(phsu_pkg::CFG_SURFACE, phsu_pkg::CFG_W'(srf));
        cfg_write(phsu_pkg::CFG_LAMP, phsu_pkg::CFG_W'(lmp));
        cfg_write(phsu_pkg::CFG_MODE, phsu_pkg::CFG_W'(md));
    endtask

    // one hit beat: optional gap, offer, wait for accept
    task automatic send_hit(hit_t h);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            hit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        {hit_x, hit_y, hit_z, norm_x, norm_y, norm_z,
         eye_x, eye_y, eye_z, lamp_x, lamp_y, lamp_z} <= h;
        hit_valid <= 1'b1;
        do
            @(posedge clk);
        while (!hit_ready);
        expected_shades.push_back(shade_predict(h));
    endtask

    task automatic drain();
        hit_valid <= 1'b0;
        while (expected_shades.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand32();
        return $urandom;
    endfunction

    // mostly a lamp and eye on the normal side of a random normal with components in [-1, 1], some pure noise
    function automatic hit_t make_hit();
        hit_t h;
        int   n [3];
        int   hp [3];
        int   kl, ke, sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            h.hx = rand32();
            h.hy = rand32();
            h.hz = rand32();
            h.nx = rand32() & 32'hFFFF;
            h.ny = 16'(rand32());
            h.nz = 16'(rand32());
            h.ex = rand32();
            h.ey = rand32();
            h.ez = rand32();
            h.lx = rand32();
            h.ly = rand32();
            h.lz = rand32();
            return h;
        end
        for (int i = 0; i < 3; i++)
        begin
            n[i] = int'($urandom_range(0, 32768)) - 16384;
            hp[i] = $signed(rand32()) >>> $urandom_range(4, 20);
        end
        kl = $urandom_range(1, 64);
        ke = $urandom_range(1, 64);
        h.hx = hp[0];
        h.hy = hp[1];
        h.hz = hp[2];
        h.nx = 16'(n[0]);
        h.ny = 16'(n[1]);
        h.nz = 16'(n[2]);
        h.ex = hp[0] + n[0] * ke + ($signed(rand32()) >>> 14);
        h.ey = hp[1] + n[1] * ke + ($signed(rand32()) >>> 14);
        h.ez = hp[2] + n[2] * ke + ($signed(rand32()) >>> 14);
        h.lx = (mode_q ? 0 : hp[0]) + n[0] * kl + ($signed(rand32()) >>> 13);
        h.ly = (mode_q ? 0 : hp[1]) + n[1] * kl + ($signed(rand32()) >>> 13);
        h.lz = (mode_q ? 0 : hp[2]) + n[2] * kl + ($signed(rand32()) >>> 13);
        return h;
    endfunction

    task automatic send_random(int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 64 == 0)
            begin
                tx_calm = ($urandom_range(0, 4) == 0);
                rx_calm = ($urandom_range(0, 4) == 0);
            end
            send_hit(make_hit());
        end
        tx_calm = 0;
        rx_calm = 0;
    endtask

    // extremes of the fields and the named corner cases
    task automatic test_directed();
        hit_t h;
        // lit straight on, reset registers
        send_hit({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                  32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000});
        // lamp behind the surface: unlit
        send_hit({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                  32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFE_0000});
        // eye on the hit point: zero view vector
        send_hit({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                  32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0002_0000});
        // lamp on the hit point: zero light vector
        send_hit({32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                  32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0});
        // oversized normals at both extremes
        send_hit({32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  32'h0003_0000, 32'h0003_0000, 32'h0003_0000});
        send_hit({32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000,
                  32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'hFFFD_0000, 32'hFFFE_0000, 32'hFFFF_0000});
        // grazing eye: reflection points away from the viewer
        send_hit({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                  32'h0001_0000, 32'h0, 32'h0000_0100, 32'h0001_0000, 32'h0, 32'h0001_0000});
        // mirror direction: specular peak
        send_hit({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000,
                  32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000});
        // coordinate extremes
        send_hit({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h4000, 16'h0,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        send_hit({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h2D41, 16'h2D41, 16'h0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        send_hit({32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 16'hC000, 16'h0, 16'h0,
                  32'hFFFF_FFF0, 32'h0000_0001, 32'h0, 32'hFFFF_FF00, 32'h0000_0010, 32'h0});
        for (int k = 0; k < 6; k++)
        begin
            h = make_hit();
            send_hit(h);
        end
        drain();
    endtask

    // register extremes and the ignored index, one phase per setting
    task automatic test_register_sweep();
        cfg_all(16'h0000, 16'hFFFF, 8'd1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        cfg_write(CFG_UNUSED, 48'h0);
        send_random(150);
        drain();
        cfg_all(16'hFFFF, 16'hFFFF, 8'd255, 48'hFFFF_0000_8000, 48'h0000_FFFF_0100, 1'b0);
        send_random(150);
        drain();
        cfg_all(16'hFFFF, 16'h0000, 8'd0, 48'h0000_0000_0000, 48'h0000_0000_0000, 1'b0);
        send_random(80);
        drain();
        cfg_all(16'hFFFF, 16'hFFFF, 8'd2, 48'hFFFF_FFFF_FFFF, 48'h0100_0100_0100, 1'b1);
        send_random(200);
        drain();
        cfg_write(phsu_pkg::CFG_SHINE, 48'h0);
        send_random(60);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_all(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)),
                    48'({$urandom, $urandom}),
                    48'({16'($urandom_range(0, 4095)), $urandom}), ph[0]);
            send_random(150);
            drain();
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        cfg_all(16'h8000, 16'h8000, 8'd16, 48'hFFFF_FFFF_FFFF, 48'h0100_0100_0100, 1'b0);
        rx_hold = 400;
        tx_calm = 1;
        for (int k = 0; k < 180; k++)
            send_hit(make_hit());
        tx_calm = 0;
        drain();
    endtask

    // receiver ready with random stalls
    initial
    begin
        int gap;
        shade_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                shade_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                shade_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            shade_ready <= 1'b1;
        end
    end

    // compare each shade beat with the oldest expected one
    always @(posedge clk)
    begin
        shade_t got, want;
        if (rst_n && shade_valid && shade_ready)
        begin
            got = {out_red, out_green, out_blue, lit};
            if (expected_shades.size() == 0)
            begin
                $display("%0t: unexpected shade beat, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_shades.pop_front();
                if (got.red !== want.red)
                begin
                    $display("%0t: red expected %h actual %h", $time, want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green)
                begin
                    $display("%0t: green expected %h actual %h", $time, want.green, got.green);
                    errors++;
                end
                if (got.blue !== want.blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
                    errors++;
                end
                if (got.lit !== want.lit)
                begin
                    $display("%0t: lit expected %b actual %b", $time, want.lit, got.lit);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #5ms;
        $display("[phong_shading_unit_top] ERROR");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        hit_valid <= 1'b0;
        {hit_x, hit_y, hit_z, norm_x, norm_y, norm_z,
         eye_x, eye_y, eye_z, lamp_x, lamp_y, lamp_z} <= '0;
        kd_q = 16'hFFFF;
        ks_q = 16'h8000;
        shine_q = 8'd16;
        surface_q = 48'hFFFF_FFFF_FFFF;
        lamp_q = 48'h0100_0100_0100;
        mode_q = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_sweep();
        test_random_settings();
        test_backpressure();
        while (expected_shades.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("[phong_shading_unit_top] OK");
        else
            $display("[phong_shading_unit_top] ERROR");
        $finish;
    end

endmodule
